/* rtl/core/sfup_pkg.sv */
// Shared constants for the scrolling frame update parser.
package sfup_pkg;
    localparam int MAX_COLUMNS_DEF = 512;
    localparam int MAX_ROWS_DEF    = 128;

    localparam logic [2:0] EV_BUSY   = 3'd0;
    localparam logic [2:0] EV_REGION = 3'd1;
    localparam logic [2:0] EV_SCROLL = 3'd2;
    localparam logic [2:0] EV_LEGACY = 3'd3;
    localparam logic [2:0] EV_REJECT = 3'd4;
    localparam logic [2:0] EV_READ   = 3'd5;

    localparam logic [1:0] CFG_COLUMNS = 2'd0;
    localparam logic [1:0] CFG_ROWS    = 2'd1;

    localparam logic [9:0] COLUMNS_RST = 10'd431;
    localparam logic [7:0] ROWS_RST    = 8'd128;

    localparam logic [31:0] X_LEGACY = 32'hFFFF_FFFF;
    localparam logic [31:0] X_SCROLL = 32'hFFFF_FFFE;
    localparam logic [3:0]  HDR_LAST = 4'd15;
endpackage

/* rtl/core/sfup_store.sv */
// RGB frame store: one write port, one registered read port, clearing pass after reset.
module sfup_store #(
    parameter int AW = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [23:0]   i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [23:0]   o_rdata,
    output logic          o_busy
);
    localparam int DEPTH = 1 << AW;

    logic [23:0]   mem [DEPTH];
    logic [AW-1:0] r_clr_addr;
    logic          r_busy;
    logic [23:0]   r_rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy     <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_busy) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == {AW{1'b1}}) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            mem[r_clr_addr] <= 24'd0;
        end else if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
    assign o_busy  = r_busy;
endmodule

/* rtl/core/scrolling_frame_update_parser_top.sv */
// Scrolling frame update parser: header parse, region and scroll writes, pixel reads.
// A stream byte's result is registered and ready in the next cycle, so bytes flow at one
// per cycle while results are taken and no read, copy or base reduction holds the input.
// A pixel read passes through the registered frame store read and then the result
// register. A scroll header holds the input while the old rightmost column is copied into
// the new one, one row a cycle through the store's single read and write port. Writing
// columns_in_use holds the input while the ring base is reduced by repeated subtraction.
// After reset all 2^(clog2(MAX_ROWS)+clog2(MAX_COLUMNS)) store entries (65536 at the
// defaults) are cleared, one entry a cycle, before the first request is taken.
module scrolling_frame_update_parser_top #(
    parameter int MAX_COLUMNS = sfup_pkg::MAX_COLUMNS_DEF,
    parameter int MAX_ROWS    = sfup_pkg::MAX_ROWS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // stream_byte, read_row, read_col
    input  logic [0:0]  s_tuser,   // cmd
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // red, green, blue, columns_filled, fully_filled, scroll_count
    output logic [2:0]  m_tuser,   // event_res
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [9:0]  i_cfg_data
);
    import sfup_pkg::*;

    localparam int CAW = $clog2(MAX_COLUMNS);
    localparam int CCW = $clog2(MAX_COLUMNS + 1);
    localparam int RAW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int RCW = $clog2(MAX_ROWS + 1);
    localparam int AW  = RAW + CAW;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_READ = 2'd1;
    localparam logic [1:0] ST_COPY = 2'd2;

    localparam logic [1:0] PH_HEADER = 2'd0;
    localparam logic [1:0] PH_REGION = 2'd1;
    localparam logic [1:0] PH_SCROLL = 2'd2;

    logic [1:0]     r_state, n_state;
    logic [1:0]     r_phase, n_phase;
    logic [31:0]    r_hdr [4];
    logic [31:0]    n_hdr [4];
    logic [31:0]    nh [4];
    logic [3:0]     r_bc, n_bc;
    logic [15:0]    r_pa, n_pa;
    logic [31:0]    r_wrow, n_wrow;
    logic [CCW-1:0] r_wcol, n_wcol;
    logic [31:0]    r_left, n_left;
    logic [CAW-1:0] r_raw, n_raw;
    logic [CAW-1:0] r_bm, n_bm;
    logic           r_norm_busy, n_norm_busy;
    logic [9:0]     r_filled, n_filled;
    logic           r_flag, n_flag;
    logic [31:0]    r_scnt, n_scnt;
    logic [RCW-1:0] r_cnt, n_cnt;
    logic [CAW-1:0] r_old, n_old;
    logic [CAW-1:0] r_b, n_b;
    logic           r_fin, n_fin;
    logic           r_rd_ok, n_rd_ok;
    logic           r_ovalid, n_ovalid;
    logic [2:0]     r_ev, n_ev;
    logic [23:0]    r_rgb, n_rgb;
    logic [9:0]     r_cfg_cols, n_cfg_cols;
    logic [7:0]     r_cfg_rows, n_cfg_rows;

    logic [CCW-1:0] w;
    logic [RCW-1:0] h;
    logic           acc;
    logic           cmd;
    logic [7:0]     sb;
    logic [6:0]     rr;
    logic [8:0]     rc;

    logic           mem_we;
    logic [AW-1:0]  mem_waddr;
    logic [23:0]    mem_wdata;
    logic           mem_re;
    logic [AW-1:0]  mem_raddr;
    logic [23:0]    mem_rdata;
    logic           st_busy;

    logic [1:0]     wi;
    logic           ht_le0;
    logic           bad;
    logic [32:0]    x_sum;
    logic [32:0]    y_sum;
    logic [CCW+RCW-1:0] prod;
    logic [31:0]    row32;
    logic [31:0]    col32;
    logic           pix_ok;
    logic [31:0]    left_nx;
    logic [31:0]    right;
    logic [CAW-1:0] old_right;
    logic [CAW-1:0] nb;
    logic [RCW-1:0] cm1;

    function automatic logic [CAW-1:0] phys_col(input logic [CAW-1:0] base,
                                               input logic [CAW-1:0] c,
                                               input logic [CCW-1:0] wd);
        logic [CAW:0] s;
        s = (CAW+1)'(base) + (CAW+1)'(c);
        if (s >= (CAW+1)'(wd)) begin
            s = s - (CAW+1)'(wd);
        end
        return s[CAW-1:0];
    endfunction

    sfup_store #(.AW(AW)) u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata),
        .o_busy  (st_busy)
    );

    // clamp the configured size to the store
    always_comb begin
        if (r_cfg_cols == 10'd0) begin
            w = CCW'(1);
        end else if (32'(r_cfg_cols) > MAX_COLUMNS) begin
            w = CCW'(MAX_COLUMNS);
        end else begin
            w = CCW'(r_cfg_cols);
        end
        if (r_cfg_rows == 8'd0) begin
            h = RCW'(1);
        end else if (32'(r_cfg_rows) > MAX_ROWS) begin
            h = RCW'(MAX_ROWS);
        end else begin
            h = RCW'(r_cfg_rows);
        end
    end

    assign cmd = s_tuser[0];
    assign sb  = s_tdata[7:0];
    assign rr  = s_tdata[14:8];
    assign rc  = s_tdata[23:15];

    assign s_tready = (r_state == ST_IDLE) && !st_busy && !r_norm_busy &&
                      (!r_ovalid || m_tready);
    assign acc = s_tvalid && s_tready;

    assign m_tvalid = r_ovalid;
    assign m_tuser  = r_ev;
    assign m_tdata  = {5'd0, r_scnt, r_flag, r_filled, r_rgb[7:0], r_rgb[15:8], r_rgb[23:16]};

    // header word assembly and checks on the header as it stands after this byte
    always_comb begin
        wi = r_bc[3:2];
        for (int i = 0; i < 4; i++) begin
            nh[i] = r_hdr[i];
        end
        if (r_bc[1:0] == 2'd0) begin
            nh[wi] = {24'd0, sb};
        end else begin
            nh[wi] = r_hdr[wi] | (32'(sb) << {r_bc[1:0], 3'b000});
        end
        ht_le0 = nh[3][31] || (nh[3] == 32'd0);
        x_sum  = {1'b0, nh[0]} + {1'b0, nh[2]};
        y_sum  = {1'b0, nh[1]} + {1'b0, nh[3]};
        bad    = nh[0][31] || nh[1][31] || nh[2][31] || (nh[2] == 32'd0) || ht_le0 ||
                 (x_sum > 33'(w)) || (y_sum > 33'(h));
        prod   = nh[2][CCW-1:0] * nh[3][RCW-1:0];
    end

    // pixel target and ring arithmetic
    always_comb begin
        if (r_phase == PH_SCROLL) begin
            row32 = r_wrow;
            col32 = 32'(w) - 32'd1;
        end else begin
            row32 = r_hdr[1] + r_wrow;
            col32 = r_hdr[0] + 32'(r_wcol);
        end
        pix_ok    = (row32 < 32'(h)) && (col32 < 32'(w));
        left_nx   = (r_left != 32'd0) ? r_left - 32'd1 : 32'd0;
        right     = r_hdr[0] + r_hdr[2];
        old_right = (r_bm == '0) ? CAW'(w - CCW'(1)) : r_bm - CAW'(1);
        nb        = (CCW'(r_b) == w - CCW'(1)) ? '0 : r_b + CAW'(1);
        cm1       = r_cnt - RCW'(1);
    end

    always_comb begin
        n_state     = r_state;
        n_phase     = r_phase;
        n_hdr       = r_hdr;
        n_bc        = r_bc;
        n_pa        = r_pa;
        n_wrow      = r_wrow;
        n_wcol      = r_wcol;
        n_left      = r_left;
        n_raw       = r_raw;
        n_bm        = r_bm;
        n_norm_busy = r_norm_busy;
        n_filled    = r_filled;
        n_flag      = r_flag;
        n_scnt      = r_scnt;
        n_cnt       = r_cnt;
        n_old       = r_old;
        n_b         = r_b;
        n_fin       = r_fin;
        n_rd_ok     = r_rd_ok;
        n_ovalid    = r_ovalid;
        n_ev        = r_ev;
        n_rgb       = r_rgb;
        n_cfg_cols  = r_cfg_cols;
        n_cfg_rows  = r_cfg_rows;
        mem_we      = 1'b0;
        mem_waddr   = {row32[RAW-1:0], phys_col(r_bm, col32[CAW-1:0], w)};
        mem_wdata   = {r_pa, sb};
        mem_re      = 1'b0;
        mem_raddr   = {RAW'(rr), phys_col(r_bm, CAW'(rc), w)};

        // apply configuration writes and reduce the ring base against a new width
        if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_COLUMNS: begin
                    n_cfg_cols  = i_cfg_data;
                    n_norm_busy = 1'b1;
                    n_bm        = r_raw;
                end
                CFG_ROWS: begin
                    n_cfg_rows = i_cfg_data[7:0];
                end
                default: ;
            endcase
        end else if (r_norm_busy) begin
            if (CCW'(r_bm) >= w) begin
                n_bm = CAW'(CCW'(r_bm) - w);
            end else begin
                n_norm_busy = 1'b0;
            end
        end

        if (r_ovalid && m_tready) begin
            n_ovalid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (acc) begin
                    if (cmd) begin
                        mem_re  = 1'b1;
                        n_rd_ok = (32'(rr) < 32'(h)) && (32'(rc) < 32'(w));
                        n_state = ST_READ;
                    end else if (r_phase == PH_HEADER) begin
                        n_hdr = nh;
                        if (r_bc == HDR_LAST) begin
                            n_bc = 4'd0;
                            n_pa = 16'd0;
                            if (nh[0] == X_LEGACY) begin
                                n_ovalid = 1'b1;
                                n_ev     = EV_LEGACY;
                                n_rgb    = 24'd0;
                            end else if (nh[0] == X_SCROLL) begin
                                n_old   = old_right;
                                n_b     = r_bm;
                                n_cnt   = '0;
                                n_fin   = ht_le0;
                                n_state = ST_COPY;
                                if (!ht_le0) begin
                                    n_phase = PH_SCROLL;
                                    n_left  = nh[3];
                                    n_wrow  = 32'd0;
                                    n_wcol  = '0;
                                end
                            end else if (bad) begin
                                n_ovalid = 1'b1;
                                n_ev     = EV_REJECT;
                                n_rgb    = 24'd0;
                            end else begin
                                n_phase  = PH_REGION;
                                n_left   = 32'(prod);
                                n_wrow   = 32'd0;
                                n_wcol   = '0;
                                n_ovalid = 1'b1;
                                n_ev     = EV_BUSY;
                                n_rgb    = 24'd0;
                            end
                        end else begin
                            n_bc     = r_bc + 4'd1;
                            n_ovalid = 1'b1;
                            n_ev     = EV_BUSY;
                            n_rgb    = 24'd0;
                        end
                    end else begin
                        n_ovalid = 1'b1;
                        n_ev     = EV_BUSY;
                        n_rgb    = 24'd0;
                        if (r_bc == 4'd0) begin
                            n_pa = {sb, 8'd0};
                            n_bc = 4'd1;
                        end else if (r_bc == 4'd1) begin
                            n_pa = {r_pa[15:8], sb};
                            n_bc = 4'd2;
                        end else begin
                            // third byte completes the pixel: store it if in the frame and advance
                            n_bc   = 4'd0;
                            n_pa   = 16'd0;
                            mem_we = pix_ok;
                            n_left = left_nx;
                            if (r_phase == PH_SCROLL) begin
                                n_wrow = r_wrow + 32'd1;
                            end else if (32'(r_wcol) + 32'd1 >= r_hdr[2]) begin
                                n_wcol = '0;
                                n_wrow = r_wrow + 32'd1;
                            end else begin
                                n_wcol = r_wcol + CCW'(1);
                            end
                            if (left_nx == 32'd0) begin
                                n_phase = PH_HEADER;
                                if (r_phase == PH_SCROLL) begin
                                    n_flag   = 1'b1;
                                    n_scnt   = r_scnt + 32'd1;
                                    n_filled = 10'(w);
                                    n_ev     = EV_SCROLL;
                                end else begin
                                    if (!r_flag && (right > 32'(r_filled))) begin
                                        n_filled = right[9:0];
                                    end
                                    n_ev = EV_REGION;
                                end
                            end
                        end
                    end
                end
            end
            ST_READ: begin
                n_ovalid = 1'b1;
                n_ev     = EV_READ;
                n_rgb    = r_rd_ok ? mem_rdata : 24'd0;
                n_state  = ST_IDLE;
            end
            ST_COPY: begin
                // read row r_cnt of the old right column, write row r_cnt-1 of the new one
                mem_re    = (r_cnt < h);
                mem_raddr = {r_cnt[RAW-1:0], r_old};
                mem_we    = (r_cnt != '0);
                mem_waddr = {cm1[RAW-1:0], r_b};
                mem_wdata = mem_rdata;
                n_cnt     = r_cnt + RCW'(1);
                if (r_cnt == h) begin
                    n_raw    = nb;
                    n_bm     = nb;
                    n_state  = ST_IDLE;
                    n_ovalid = 1'b1;
                    n_rgb    = 24'd0;
                    n_ev     = EV_BUSY;
                    if (r_fin) begin
                        n_flag   = 1'b1;
                        n_scnt   = r_scnt + 32'd1;
                        n_filled = 10'(w);
                        n_ev     = EV_SCROLL;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_phase     <= PH_HEADER;
            for (int i = 0; i < 4; i++) begin
                r_hdr[i] <= 32'd0;
            end
            r_bc        <= 4'd0;
            r_pa        <= 16'd0;
            r_wrow      <= 32'd0;
            r_wcol      <= '0;
            r_left      <= 32'd0;
            r_raw       <= '0;
            r_bm        <= '0;
            r_norm_busy <= 1'b0;
            r_filled    <= 10'd0;
            r_flag      <= 1'b0;
            r_scnt      <= 32'd0;
            r_cnt       <= '0;
            r_fin       <= 1'b0;
            r_rd_ok     <= 1'b0;
            r_ovalid    <= 1'b0;
            r_ev        <= EV_BUSY;
            r_cfg_cols  <= COLUMNS_RST;
            r_cfg_rows  <= ROWS_RST;
        end else begin
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_hdr       <= n_hdr;
            r_bc        <= n_bc;
            r_pa        <= n_pa;
            r_wrow      <= n_wrow;
            r_wcol      <= n_wcol;
            r_left      <= n_left;
            r_raw       <= n_raw;
            r_bm        <= n_bm;
            r_norm_busy <= n_norm_busy;
            r_filled    <= n_filled;
            r_flag      <= n_flag;
            r_scnt      <= n_scnt;
            r_cnt       <= n_cnt;
            r_fin       <= n_fin;
            r_rd_ok     <= n_rd_ok;
            r_ovalid    <= n_ovalid;
            r_ev        <= n_ev;
            r_cfg_cols  <= n_cfg_cols;
            r_cfg_rows  <= n_cfg_rows;
        end
    end

    always_ff @(posedge i_clk) begin
        r_old <= n_old;
        r_b   <= n_b;
        r_rgb <= n_rgb;
    end

    a_no_req_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        st_busy |-> !s_tready)
        else $error("request taken during store clear");

    a_result_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> !r_ovalid)
        else $error("result pending while a read or copy runs");

    a_base_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_norm_busy && r_state == ST_IDLE) |-> (CCW'(r_bm) < w))
        else $error("ring base not below width");

    a_copy_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_COPY && r_cnt == h) |=> (r_state == ST_IDLE && r_ovalid))
        else $error("scroll copy did not deliver its result");
endmodule

/* sim/tb_scrolling_frame_update_parser_top.sv */
// Testbench for the scrolling frame update parser: random stream and pixel reads vs. a predictor.
`timescale 1ns / 1ps

module tb_scrolling_frame_update_parser_top;
    import sfup_pkg::*;

    localparam int NCOL = MAX_COLUMNS_DEF;
    localparam int NROW = MAX_ROWS_DEF;
    localparam logic [1:0] PH_HEADER = 2'd0;
    localparam logic [1:0] PH_REGION = 2'd1;
    localparam logic [1:0] PH_SCROLL = 2'd2;

    typedef struct packed {
        logic       cmd;
        logic [7:0] sb;
        logic [6:0] rr;
        logic [8:0] rc;
    } req_t;

    typedef struct packed {
        logic [2:0]  ev;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [9:0]  cols;
        logic        full;
        logic [31:0] scrolls;
    } upd_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;
    logic [0:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [71:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_idx = '0;
    logic [9:0]  i_cfg_data = '0;

    scrolling_frame_update_parser_top u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // predictor state
    logic [23:0] pix_mem [0:NROW*NCOL-1];
    logic [31:0] hdr [0:3];
    logic [1:0]  phase;
    int unsigned hdr_cnt, pix_acc, wr_row, wr_col, col_base, filled, scrolls;
    logic        scrolled;
    longint unsigned px_left;
    logic [9:0]  cfg_cols;
    logic [7:0]  cfg_rows;

    req_t pend_q[$];
    upd_t upd_q[$];
    int   errors = 0;
    int   n_accepted = 0;

    function automatic int unsigned w_eff();
        if (cfg_cols < 1) return 1;
        if (cfg_cols > NCOL) return NCOL;
        return cfg_cols;
    endfunction

    function automatic int unsigned h_eff();
        if (cfg_rows < 1) return 1;
        if (cfg_rows > NROW) return NROW;
        return cfg_rows;
    endfunction

    function automatic int unsigned phys(int unsigned row, int unsigned col);
        int unsigned w;
        w = w_eff();
        return row * NCOL + ((col_base % w) + col) % w;
    endfunction

    function automatic void put_pix(int unsigned row, int unsigned col, logic [23:0] rgb);
        if (row < h_eff() && col < w_eff()) pix_mem[phys(row, col)] = rgb;
    endfunction

    function automatic void end_scroll();
        scrolled = 1'b1;
        scrolls  = scrolls + 1;
        filled   = w_eff();
        phase    = PH_HEADER;
    endfunction

    function automatic logic [2:0] decode_header();
        longint x, y, wd, ht;
        int unsigned w, b, old_right;
        x  = longint'($signed(hdr[0]));
        y  = longint'($signed(hdr[1]));
        wd = longint'($signed(hdr[2]));
        ht = longint'($signed(hdr[3]));
        hdr_cnt = 0;
        pix_acc = 0;
        if (hdr[0] == X_LEGACY) return EV_LEGACY;
        if (hdr[0] == X_SCROLL) begin
            // repeat the old rightmost column into the one that becomes rightmost
            w = w_eff();
            b = col_base % w;
            old_right = (b + w - 1) % w;
            for (int r = 0; r < h_eff(); r++) pix_mem[r*NCOL + b] = pix_mem[r*NCOL + old_right];
            col_base = (b + 1) % w;
            if (ht <= 0) begin
                end_scroll();
                return EV_SCROLL;
            end
            phase = PH_SCROLL;
            px_left = ht;
            wr_row = 0;
            wr_col = 0;
            return EV_BUSY;
        end
        if (x < 0 || y < 0 || wd <= 0 || ht <= 0 ||
            x + wd > longint'(w_eff()) || y + ht > longint'(h_eff())) return EV_REJECT;
        phase = PH_REGION;
        px_left = wd * ht;
        wr_row = 0;
        wr_col = 0;
        return EV_BUSY;
    endfunction

    function automatic logic [2:0] take_pixel_byte(logic [7:0] b);
        logic [23:0] rgb;
        int unsigned right;
        if (hdr_cnt < 2) begin
            pix_acc = (pix_acc | (int'(b) << (8 * (1 - hdr_cnt)))) & 32'hFFFF;
            hdr_cnt++;
            return EV_BUSY;
        end
        rgb = {pix_acc[15:0], b};
        hdr_cnt = 0;
        pix_acc = 0;
        if (phase == PH_SCROLL) begin
            put_pix(wr_row, w_eff() - 1, rgb);
            wr_row++;
        end else begin
            put_pix(hdr[1] + wr_row, hdr[0] + wr_col, rgb);
            wr_col++;
            if (wr_col >= hdr[2]) begin
                wr_col = 0;
                wr_row++;
            end
        end
        if (px_left > 0) px_left--;
        if (px_left != 0) return EV_BUSY;
        if (phase == PH_SCROLL) begin
            end_scroll();
            return EV_SCROLL;
        end
        if (!scrolled) begin
            right = hdr[0] + hdr[2];
            if (right > filled) filled = right & 32'h3FF;
        end
        phase = PH_HEADER;
        return EV_REGION;
    endfunction

    function automatic upd_t predict_update(req_t rq);
        upd_t u;
        logic [23:0] p;
        int unsigned wi;
        u = '0;
        if (rq.cmd) begin
            u.ev = EV_READ;
            if (rq.rr < h_eff() && rq.rc < w_eff()) begin
                p = pix_mem[phys(rq.rr, rq.rc)];
                {u.red, u.green, u.blue} = p;
            end
        end else if (phase == PH_HEADER) begin
            wi = (hdr_cnt >> 2) & 3;
            if ((hdr_cnt & 3) == 0) hdr[wi] = '0;
            hdr[wi] = hdr[wi] | (32'(rq.sb) << (8 * (hdr_cnt & 3)));
            hdr_cnt++;
            if (hdr_cnt >= 16) u.ev = decode_header();
        end else begin
            u.ev = take_pixel_byte(rq.sb);
        end
        u.cols    = filled[9:0];
        u.full    = scrolled;
        u.scrolls = scrolls;
        return u;
    endfunction

    // driver: bursts with random gaps
    int burst_left = 0;
    int gap_left = 0;
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_tvalid && s_tready) begin
                upd_q = {upd_q, predict_update(pend_q.pop_front())};
                n_accepted++;
            end
            if (s_tvalid && !s_tready) begin
                // hold the offered request
            end else if (gap_left > 0) begin
                gap_left--;
                s_tvalid <= 1'b0;
            end else if (pend_q.size() > 0) begin
                s_tvalid <= 1'b1;
                s_tdata  <= {pend_q[0].rc, pend_q[0].rr, pend_q[0].sb};
                s_tuser  <= pend_q[0].cmd;
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(1, 30);
                    gap_left   = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 6);
                end
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // monitor: own stall pattern plus one long hold-off
    int  hold_cnt = 0;
    bit  hold_done = 0;
    int  mode_cnt = 0;
    bit  choppy = 0;
    always @(posedge i_clk) begin
        upd_t e, got;
        if (i_rst_n) begin
            if (m_tvalid && m_tready) begin
                got = {m_tuser, m_tdata[7:0], m_tdata[15:8], m_tdata[23:16],
                       m_tdata[33:24], m_tdata[34], m_tdata[66:35]};
                if (upd_q.size() == 0) begin
                    $error("update with none pending: %p", got);
                    errors++;
                end else begin
                    e = upd_q.pop_front();
                    if (got.ev != e.ev) begin
                        $error("event_res exp %0d got %0d", e.ev, got.ev); errors++;
                    end
                    if (got.red != e.red) begin
                        $error("red exp %0d got %0d", e.red, got.red); errors++;
                    end
                    if (got.green != e.green) begin
                        $error("green exp %0d got %0d", e.green, got.green); errors++;
                    end
                    if (got.blue != e.blue) begin
                        $error("blue exp %0d got %0d", e.blue, got.blue); errors++;
                    end
                    if (got.cols != e.cols) begin
                        $error("columns_filled exp %0d got %0d", e.cols, got.cols); errors++;
                    end
                    if (got.full != e.full) begin
                        $error("fully_filled exp %0d got %0d", e.full, got.full); errors++;
                    end
                    if (got.scrolls != e.scrolls) begin
                        $error("scroll_count exp %0d got %0d", e.scrolls, got.scrolls);
                        errors++;
                    end
                end
            end
            if (!hold_done && n_accepted >= 150) begin
                hold_done = 1;
                hold_cnt  = 400;
            end
            if (mode_cnt == 0) begin
                mode_cnt = $urandom_range(20, 80);
                choppy   = !choppy;
            end else begin
                mode_cnt--;
            end
            if (hold_cnt > 0) begin
                hold_cnt--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= choppy ? ($urandom_range(0, 2) != 0) : 1'b1;
            end
        end
    end

    // stimulus
    task automatic push_read(int unsigned rr, int unsigned rc);
        req_t q;
        q = '0;
        q.cmd = 1'b1;
        q.rr  = 7'(rr);
        q.rc  = 9'(rc);
        pend_q = {pend_q, q};
    endtask

    task automatic push_rand_read();
        if ($urandom_range(0, 1)) begin
            push_read($urandom_range(0, h_eff() - 1), $urandom_range(0, w_eff() - 1));
        end else begin
            push_read($urandom, $urandom);
        end
    endtask

    task automatic push_byte(logic [7:0] b, bit mix_reads);
        req_t q;
        if (mix_reads && $urandom_range(0, 99) < 8) push_rand_read();
        q = '0;
        q.sb = b;
        q.rr = 7'($urandom);
        q.rc = 9'($urandom);
        pend_q = {pend_q, q};
    endtask

    task automatic push_header(logic [31:0] x, logic [31:0] y, logic [31:0] wd, logic [31:0] ht);
        logic [127:0] h;
        h = {ht, wd, y, x};
        for (int i = 0; i < 16; i++) push_byte(h[8*i +: 8], 1);
    endtask

    task automatic push_pixels(int n);
        for (int i = 0; i < 3 * n; i++) push_byte(8'($urandom), 1);
    endtask

    task automatic push_random_message();
        int unsigned r, w, h, wd, ht, x, y;
        int sh;
        r = $urandom_range(0, 99);
        w = w_eff();
        h = h_eff();
        if (r < 45) begin
            wd = $urandom_range(1, (w < 3) ? w : 3);
            ht = $urandom_range(1, (h < 3) ? h : 3);
            x  = $urandom_range(0, w - wd);
            y  = $urandom_range(0, h - ht);
            push_header(x, y, wd, ht);
            push_pixels(wd * ht);
        end else if (r < 65) begin
            sh = $urandom_range(0, ((h < 5) ? h : 5) + 2) - 1;
            push_header(X_SCROLL, $urandom, $urandom, sh);
            if (sh > 0) push_pixels(sh);
        end else if (r < 72) begin
            push_header(X_LEGACY, $urandom, $urandom, $urandom);
        end else if (r < 88) begin
            case ($urandom_range(0, 4))
                0: push_header(-$urandom_range(3, 9), 0, 1, 1);
                1: push_header(0, -$urandom_range(1, 9), 1, 1);
                2: push_header(0, 0, 0, 1);
                3: push_header(w - 1, 0, 2, 1);
                default: push_header(0, h - 1, 1, $urandom_range(2, 4));
            endcase
        end else if (r < 95) begin
            repeat ($urandom_range(1, 3)) push_byte(8'($urandom), 0);
        end else begin
            push_rand_read();
        end
    endtask

    task automatic drain();
        do @(posedge i_clk);
        while (pend_q.size() != 0 || upd_q.size() != 0 || s_tvalid);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_cfg(logic [1:0] idx, logic [9:0] val);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        if (idx == CFG_COLUMNS) cfg_cols = val;
        else if (idx == CFG_ROWS) cfg_rows = val[7:0];
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic random_phase(logic [9:0] cols, logic [9:0] rows, int n_items);
        int start;
        write_cfg(CFG_COLUMNS, cols);
        write_cfg(CFG_ROWS, rows);
        start = pend_q.size() + n_accepted;
        while (pend_q.size() + n_accepted - start < n_items) push_random_message();
    endtask

    initial begin
        for (int i = 0; i < NROW*NCOL; i++) pix_mem[i] = '0;
        for (int i = 0; i < 4; i++) hdr[i] = '0;
        phase = PH_HEADER;
        hdr_cnt = 0; pix_acc = 0; wr_row = 0; wr_col = 0; col_base = 0;
        filled = 0; scrolls = 0; scrolled = 1'b0; px_left = 0;
        cfg_cols = COLUMNS_RST;
        cfg_rows = ROWS_RST;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed, reset configuration
        push_read(0, 0);
        push_header(0, 0, 2, 1);
        push_pixels(1);
        push_read(0, 1);                 // read in the middle of a region
        push_pixels(1);
        push_header(429, 127, 2, 1);
        push_byte(8'hFF, 0); push_byte(8'h00, 0); push_byte(8'hFF, 0);
        push_byte(8'h00, 0); push_byte(8'hFF, 0); push_byte(8'h00, 0);
        push_read(127, 430);
        push_read(127, 431);             // column out of range
        push_read(127, 511);
        push_header(X_LEGACY, 0, 0, 0);
        push_header(-3, 0, 1, 1);
        push_header(0, 0, 0, 1);
        push_header(430, 0, 2, 1);
        push_header(0, 127, 1, 2);
        push_header(X_SCROLL, 0, 0, 0);  // scroll without data
        push_header(X_SCROLL, 0, 0, -5);
        push_header(X_SCROLL, 0, 0, 1);
        push_pixels(1);
        push_read(0, 430);
        push_read(5, 430);
        drain();

        random_phase(10'd1023, 10'd255, 20);
        drain();
        random_phase(10'd8, 10'd4, 40);
        drain();
        random_phase(10'd0, 10'd0, 20);
        drain();
        random_phase(10'd512, 10'd128, 20);
        // leave a region open across the next setting change
        push_header(500, 0, 3, 3);
        push_pixels(2);
        drain();
        random_phase(10'd5, 10'd3, 25);
        push_header(X_SCROLL, 0, 0, 5);  // taller than the frame
        push_pixels(5);
        push_read(2, 4);
        drain();

        if (errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    initial begin
        #10ms;
        $display("FAILURE");
        $finish;
    end
endmodule

/* files.f */
rtl/core/sfup_pkg.sv
rtl/core/sfup_store.sv
rtl/core/scrolling_frame_update_parser_top.sv
sim/tb_scrolling_frame_update_parser_top.sv
